FILE: src/pra_pkg.sv
// pra_pkg: shared constants, CORDIC angle table and pipeline sideband type
// for the planar refraction angle pipeline; no dependencies
package pra_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int UP           = 32 - ANGLE_BITS;
  localparam int INDEX_W      = 14;
  localparam int CW           = 34;
  localparam int CORDIC_STEPS = 30;
  localparam int DIV_STEPS    = 31;
  localparam int SQRT_STEPS   = 31;
  localparam int PROD_W       = 31 + INDEX_W;
  localparam int LATENCY      = 4 + 2 * CORDIC_STEPS + DIV_STEPS + SQRT_STEPS;

  localparam logic [ANGLE_BITS-2:0] QUARTER = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 2);
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // register indexes of the configuration port
  localparam logic CFG_INDEX_INSIDE  = 1'b0;
  localparam logic CFG_INDEX_OUTSIDE = 1'b1;

  // atan(2^-i) in 32-bit turn fractions
  localparam logic signed [CW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4, 34'sh028B0D43,
    34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55, 34'sh0028BE53, 34'sh00145F2F,
    34'sh000A2F98, 34'sh000517CC, 34'sh00028BE6, 34'sh000145F3, 34'sh0000A2FA,
    34'sh0000517D, 34'sh000028BE, 34'sh0000145F, 34'sh00000A30, 34'sh00000518,
    34'sh0000028C, 34'sh00000146, 34'sh000000A3, 34'sh00000051, 34'sh00000029,
    34'sh00000014, 34'sh0000000A, 34'sh00000005, 34'sh00000003, 34'sh00000001
  };

  // per-request data that travels alongside the arithmetic
  typedef struct packed {
    logic [ANGLE_BITS-1:0] nrm;
    logic [ANGLE_BITS-1:0] d;
    logic [INDEX_W-1:0]    n1;
    logic [INDEX_W-1:0]    n2;
    logic                  tir;
  } side_t;

endpackage

FILE: src/planar_refraction_angle.sv
// planar_refraction_angle: top level of the 2D refraction pipeline
// depends on pra_pkg, pra_sin_cordic, pra_divider, pra_isqrt, pra_asin_cordic
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  request  | start_i, busy_o       | incident_angle_i, normal_angle_i
//  result   | done_o (one cycle)    | refracted_angle_o, total_reflection_o
//  config   | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// one request per cycle; each request passes the entry, product, radicand
// and output registers, the two 30-step CORDIC chains and the 31-step divider
// and root stages; reset clears all valid bits and sets both indexes to 1.0
// busy_o stays low: the pipeline never stalls, and results cannot be held off
module planar_refraction_angle import pra_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [ANGLE_BITS-1:0] incident_angle_i,
  input  logic [ANGLE_BITS-1:0] normal_angle_i,
  output logic                  done_o,
  output logic [ANGLE_BITS-1:0] refracted_angle_o,
  output logic                  total_reflection_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [INDEX_W-1:0]    cfg_data_i
);

  logic [INDEX_W-1:0] idx_in_q, idx_out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_in_q  <= INDEX_W'(4096);
      idx_out_q <= INDEX_W'(4096);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INDEX_INSIDE:  idx_in_q  <= cfg_data_i;
        CFG_INDEX_OUTSIDE: idx_out_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // entry stage: fold relative angle into first quadrant
  logic                  acc;
  logic [ANGLE_BITS-1:0] d;
  logic [1:0]            q;
  logic [ANGLE_BITS-3:0] r;
  logic [ANGLE_BITS-2:0] th1;
  logic                  leaving;
  side_t                 s0_side_d, s0_side_q;
  logic                  s0_v_q;
  logic [31:0]           s0_ang_q;

  assign acc     = start_i && !busy_o;
  assign d       = incident_angle_i - normal_angle_i;
  assign q       = d[ANGLE_BITS-1:ANGLE_BITS-2];
  assign r       = d[ANGLE_BITS-3:0];
  assign th1     = (q == 2'd0 || q == 2'd2) ? (ANGLE_BITS-1)'(r) : QUARTER - (ANGLE_BITS-1)'(r);
  assign leaving = (q == 2'd0) || (q == 2'd3 && r != '0);

  always_comb begin
    s0_side_d.nrm = normal_angle_i;
    s0_side_d.d   = d;
    s0_side_d.n1  = leaving ? idx_in_q : idx_out_q;
    s0_side_d.n2  = leaving ? idx_out_q : idx_in_q;
    s0_side_d.tir = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else begin
      s0_v_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_side_q <= s0_side_d;
    s0_ang_q  <= 32'(th1) << UP;
  end

  // sine of incidence
  logic        sin_v;
  side_t       sin_side;
  logic [30:0] sin_val;

  pra_sin_cordic u_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_v_q),
    .side_i  (s0_side_q),
    .ang_i   (s0_ang_q),
    .valid_o (sin_v),
    .side_o  (sin_side),
    .sin_o   (sin_val)
  );

  // product with n1 and total reflection test
  logic [PROD_W-1:0] prod_d, prod_q;
  side_t             mul_side_d, mul_side_q;
  logic              mul_v_q;

  assign prod_d = PROD_W'(sin_val) * PROD_W'(sin_side.n1);

  always_comb begin
    mul_side_d     = sin_side;
    mul_side_d.tir = (sin_side.n2 <= sin_side.n1) &&
                     (prod_d >= (PROD_W'(sin_side.n2) << 30));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
    end else begin
      mul_v_q <= sin_v;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    mul_side_q <= mul_side_d;
  end

  // divide by n2
  logic        div_v;
  side_t       div_side;
  logic [30:0] quo;

  pra_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_v_q),
    .side_i  (mul_side_q),
    .prod_i  (prod_q),
    .valid_o (div_v),
    .side_o  (div_side),
    .quo_o   (quo)
  );

  // clamp t and form the radicand 1 - t^2
  logic [30:0] t_c;
  logic [61:0] sq;
  logic [30:0] sq_t_q;
  logic [61:0] sq_rad_q;
  side_t       sq_side_q;
  logic        sq_v_q;

  assign t_c = (quo > ONE_Q30) ? ONE_Q30 : quo;
  assign sq  = 62'(t_c) * 62'(t_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= 1'b0;
    end else begin
      sq_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_t_q    <= t_c;
    sq_rad_q  <= (62'(1) << 60) - sq;
    sq_side_q <= div_side;
  end

  // cosine term by square root
  logic        rt_v;
  side_t       rt_side;
  logic [30:0] rt_t, rt_x;

  pra_isqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_v_q),
    .side_i  (sq_side_q),
    .t_i     (sq_t_q),
    .rad_i   (sq_rad_q),
    .valid_o (rt_v),
    .side_o  (rt_side),
    .t_o     (rt_t),
    .root_o  (rt_x)
  );

  // refraction angle
  logic                 as_v;
  side_t                as_side;
  logic signed [CW-1:0] as_z;

  pra_asin_cordic u_asin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rt_v),
    .side_i  (rt_side),
    .x_i     (rt_x),
    .y_i     (rt_t),
    .valid_o (as_v),
    .side_o  (as_side),
    .ang_o   (as_z)
  );

  // round, restore quadrant (or reflect on total reflection), add normal
  logic [30:0]           z_c;
  logic [31:0]           z_r;
  logic [ANGLE_BITS-1:0] th2_raw, th2, rel, half;
  logic [1:0]            oq;

  assign half = ANGLE_BITS'(QUARTER) << 1;
  assign oq   = as_side.d[ANGLE_BITS-1:ANGLE_BITS-2];

  always_comb begin
    if (as_z < 0) begin
      z_c = '0;
    end else if (as_z > CW'(ONE_Q30)) begin
      z_c = ONE_Q30;
    end else begin
      z_c = as_z[30:0];
    end
    z_r     = 32'(z_c) + (32'(1) << (UP - 1));
    th2_raw = ANGLE_BITS'(z_r >> UP);
    th2     = (th2_raw > ANGLE_BITS'(QUARTER)) ? ANGLE_BITS'(QUARTER) : th2_raw;
    if (as_side.tir) begin
      rel = half - as_side.d;
    end else begin
      case (oq)
        2'd0:    rel = th2;
        2'd1:    rel = half - th2;
        2'd2:    rel = half + th2;
        default: rel = '0 - th2;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= as_v;
    end
  end

  always_ff @(posedge clk_i) begin
    refracted_angle_o  <= as_side.nrm + rel;
    total_reflection_o <= as_side.tir;
  end

`ifndef SYNTH
  // every request comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##(LATENCY) done_o)
    else $error("result missing after request");

  // no result without a request
  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc, LATENCY))
    else $error("result without request");
`endif

endmodule

FILE: src/pra_sin_cordic.sv
// pra_sin_cordic: rotation-mode CORDIC sine, one iteration per stage
// depends on pra_pkg
module pra_sin_cordic import pra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  side_t       side_i,
  input  logic [31:0] ang_i,
  output logic        valid_o,
  output side_t       side_o,
  output logic [30:0] sin_o
);

  logic                 v_q    [CORDIC_STEPS];
  side_t                sd_q   [CORDIC_STEPS];
  logic                 zero_q [CORDIC_STEPS];
  logic                 full_q [CORDIC_STEPS];
  logic signed [CW-1:0] x_q    [CORDIC_STEPS];
  logic signed [CW-1:0] y_q    [CORDIC_STEPS];
  logic signed [CW-1:0] z_q    [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    logic                 v_in, zero_in, full_in;
    side_t                sd_in;
    logic signed [CW-1:0] x_in, y_in, z_in, x_d, y_d, z_d;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign sd_in   = side_i;
      assign zero_in = (ang_i == 32'd0);
      assign full_in = (ang_i >= 32'(ONE_Q30));
      assign x_in    = CORDIC_GAIN;
      assign y_in    = '0;
      assign z_in    = CW'(ang_i);
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign sd_in   = sd_q[i-1];
      assign zero_in = zero_q[i-1];
      assign full_in = full_q[i-1];
      assign x_in    = x_q[i-1];
      assign y_in    = y_q[i-1];
      assign z_in    = z_q[i-1];
    end

    // one micro-rotation
    always_comb begin
      if (z_in >= 0) begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - ATAN_TURNS[i];
      end else begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + ATAN_TURNS[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sd_q[i]   <= sd_in;
      zero_q[i] <= zero_in;
      full_q[i] <= full_in;
      x_q[i]    <= x_d;
      y_q[i]    <= y_d;
      z_q[i]    <= z_d;
    end
  end

  // exact end points and clamp to [0, 1]
  always_comb begin
    if (zero_q[CORDIC_STEPS-1] || y_q[CORDIC_STEPS-1] < 0) begin
      sin_o = '0;
    end else if (full_q[CORDIC_STEPS-1] || y_q[CORDIC_STEPS-1] > CW'(ONE_Q30)) begin
      sin_o = ONE_Q30;
    end else begin
      sin_o = y_q[CORDIC_STEPS-1][30:0];
    end
  end

  assign valid_o = v_q[CORDIC_STEPS-1];
  assign side_o  = sd_q[CORDIC_STEPS-1];

endmodule

FILE: src/pra_divider.sv
// pra_divider: restoring division of the sine-index product by n2,
// one quotient bit per stage; depends on pra_pkg
module pra_divider import pra_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  side_t             side_i,
  input  logic [PROD_W-1:0] prod_i,
  output logic              valid_o,
  output side_t             side_o,
  output logic [30:0]       quo_o
);

  logic              v_q   [DIV_STEPS];
  side_t             sd_q  [DIV_STEPS];
  logic [PROD_W-1:0] rem_q [DIV_STEPS];
  logic [30:0]       quo_q [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_stage
    logic              v_in, ge;
    side_t             sd_in;
    logic [PROD_W-1:0] rem_in, dv;
    logic [30:0]       quo_in;

    if (j == 0) begin : g_first
      assign v_in   = valid_i;
      assign sd_in  = side_i;
      assign rem_in = prod_i;
      assign quo_in = '0;
    end else begin : g_next
      assign v_in   = v_q[j-1];
      assign sd_in  = sd_q[j-1];
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    // trial subtract of the shifted divisor
    assign dv = PROD_W'(sd_in.n2) << (DIV_STEPS - 1 - j);
    assign ge = (rem_in >= dv);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sd_q[j]  <= sd_in;
      rem_q[j] <= ge ? rem_in - dv : rem_in;
      quo_q[j] <= {quo_in[29:0], ge};
    end
  end

  assign valid_o = v_q[DIV_STEPS-1];
  assign side_o  = sd_q[DIV_STEPS-1];
  assign quo_o   = quo_q[DIV_STEPS-1];

endmodule

FILE: src/pra_isqrt.sv
// pra_isqrt: integer square root, one result bit per stage; also carries t
// for the arcsine unit; depends on pra_pkg
module pra_isqrt import pra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  side_t       side_i,
  input  logic [30:0] t_i,
  input  logic [61:0] rad_i,
  output logic        valid_o,
  output side_t       side_o,
  output logic [30:0] t_o,
  output logic [30:0] root_o
);

  logic        v_q   [SQRT_STEPS];
  side_t       sd_q  [SQRT_STEPS];
  logic [30:0] t_q   [SQRT_STEPS];
  logic [61:0] rad_q [SQRT_STEPS];
  logic [61:0] res_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
    logic        v_in, ge;
    side_t       sd_in;
    logic [30:0] t_in;
    logic [61:0] rad_in, res_in, bitv, trial;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign sd_in  = side_i;
      assign t_in   = t_i;
      assign rad_in = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign sd_in  = sd_q[k-1];
      assign t_in   = t_q[k-1];
      assign rad_in = rad_q[k-1];
      assign res_in = res_q[k-1];
    end

    assign bitv  = 62'(1) << (2 * (SQRT_STEPS - 1 - k));
    assign trial = res_in + bitv;
    assign ge    = (rad_in >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sd_q[k]  <= sd_in;
      t_q[k]   <= t_in;
      rad_q[k] <= ge ? rad_in - trial : rad_in;
      res_q[k] <= ge ? (res_in >> 1) + bitv : (res_in >> 1);
    end
  end

  assign valid_o = v_q[SQRT_STEPS-1];
  assign side_o  = sd_q[SQRT_STEPS-1];
  assign t_o     = t_q[SQRT_STEPS-1];
  assign root_o  = res_q[SQRT_STEPS-1][30:0];

endmodule

FILE: src/pra_asin_cordic.sv
// pra_asin_cordic: vectoring-mode CORDIC arcsine, one iteration per stage
// depends on pra_pkg
module pra_asin_cordic import pra_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  side_t                side_i,
  input  logic [30:0]          x_i,
  input  logic [30:0]          y_i,
  output logic                 valid_o,
  output side_t                side_o,
  output logic signed [CW-1:0] ang_o
);

  logic                 v_q  [CORDIC_STEPS];
  side_t                sd_q [CORDIC_STEPS];
  logic signed [CW-1:0] x_q  [CORDIC_STEPS];
  logic signed [CW-1:0] y_q  [CORDIC_STEPS];
  logic signed [CW-1:0] z_q  [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    logic                 v_in;
    side_t                sd_in;
    logic signed [CW-1:0] x_in, y_in, z_in, x_d, y_d, z_d;

    if (i == 0) begin : g_first
      assign v_in  = valid_i;
      assign sd_in = side_i;
      assign x_in  = CW'(x_i);
      assign y_in  = CW'(y_i);
      assign z_in  = '0;
    end else begin : g_next
      assign v_in  = v_q[i-1];
      assign sd_in = sd_q[i-1];
      assign x_in  = x_q[i-1];
      assign y_in  = y_q[i-1];
      assign z_in  = z_q[i-1];
    end

    // rotate toward the x axis
    always_comb begin
      if (y_in > 0) begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + ATAN_TURNS[i];
      end else begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - ATAN_TURNS[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sd_q[i] <= sd_in;
      x_q[i]  <= x_d;
      y_q[i]  <= y_d;
      z_q[i]  <= z_d;
    end
  end

  assign valid_o = v_q[CORDIC_STEPS-1];
  assign side_o  = sd_q[CORDIC_STEPS-1];
  assign ang_o   = z_q[CORDIC_STEPS-1];

endmodule
